FILE: sv/tbp_pkg.sv
// Shared types, constants and microcode for the tetrahedron point locator.
package tbp_pkg;

  localparam int COORD_WIDTH    = 24;
  localparam int BARY_FRAC_BITS = 20;
  localparam int FIELD_W        = 24;
  localparam int BARY_W         = 24;
  localparam int COF_STEPS      = 18;
  localparam int PROD_STEPS     = 6;
  localparam int SETUP_STEPS    = COF_STEPS + PROD_STEPS;
  localparam int QUERY_STEPS    = 3 * PROD_STEPS;
  localparam int MAC_LAT        = 2;
  localparam int STEP_W         = 5;
  localparam int DRAIN_W        = $clog2(MAC_LAT);

  localparam logic KIND_VERTEX = 1'b0;
  localparam logic KIND_QUERY  = 1'b1;
  localparam logic RES_SETUP   = 1'b0;
  localparam logic RES_QUERY   = 1'b1;
  localparam logic [1:0] LAST_VERTEX = 2'd3;

  typedef struct packed {
    logic                      kind;
    logic [1:0]                vertex_index;
    logic signed [FIELD_W-1:0] coord_x;
    logic signed [FIELD_W-1:0] coord_y;
    logic signed [FIELD_W-1:0] coord_z;
  } in_item_t;

  typedef struct packed {
    logic                     result_kind;
    logic signed [BARY_W-1:0] bary_r;
    logic signed [BARY_W-1:0] bary_s;
    logic signed [BARY_W-1:0] bary_t;
    logic signed [BARY_W-1:0] bary_u;
    logic                     inside_res;
    logic                     singular;
  } out_item_t;

  typedef enum logic       {ASRC_J, ASRC_G} a_src_t;
  typedef enum logic       {BSRC_J, BSRC_D} b_src_t;
  typedef enum logic [1:0] {PART_FULL, PART_LO, PART_HI} part_t;
  typedef enum logic [1:0] {ACC_LOAD, ACC_ADD, ACC_SUB} acc_op_t;
  typedef enum logic [1:0] {DST_NONE, DST_G, DST_DET, DST_N} dst_t;
  typedef enum logic [1:0] {OUT_SETUP, OUT_SING, OUT_QUERY} out_mode_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIFF, ST_SMAC, ST_SDRAIN, ST_SCHK,
    ST_QMAC, ST_QDRAIN, ST_QN0, ST_DSTART, ST_DWAIT, ST_OUT
  } state_t;

  typedef struct packed {
    logic       mul_en;
    a_src_t     a_src;
    logic [3:0] a_idx;
    part_t      part;
    b_src_t     b_src;
    logic [3:0] b_idx;
    acc_op_t    acc_op;
    dst_t       dst;
    logic [3:0] dst_idx;
  } mac_cmd_t;

  typedef struct packed {
    logic       accept;
    logic       set_deg;
    logic       calc_diff;
    mac_cmd_t   mac;
    logic       calc_deg;
    logic       calc_n0;
    logic       div_start;
    logic [1:0] div_sel;
    logic       div_take;
    logic       out_load;
    out_mode_t  out_mode;
  } ctl_cmd_t;

  typedef struct packed {
    logic deg;
    logic div_done;
  } dp_stat_t;

  function automatic mac_cmd_t mac_idle();
    mac_cmd_t c;
    c.mul_en  = 1'b0;
    c.a_src   = ASRC_J;
    c.a_idx   = 4'd0;
    c.part    = PART_FULL;
    c.b_src   = BSRC_J;
    c.b_idx   = 4'd0;
    c.acc_op  = ACC_LOAD;
    c.dst     = DST_NONE;
    c.dst_idx = 4'd0;
    return c;
  endfunction

  // cofactors first (two products each), then det = sum g[i]*j[i] in halves
  function automatic mac_cmd_t mc_setup(input logic [STEP_W-1:0] step);
    mac_cmd_t         c;
    logic [3:0]       k;
    logic [15:0]      q;
    logic [STEP_W-1:0] off;
    c = mac_idle();
    c.mul_en = 1'b1;
    off = step - STEP_W'(COF_STEPS);
    if (step < STEP_W'(COF_STEPS)) begin
      k = step[4:1];
      case (k)
        4'd0: q = {4'd4, 4'd8, 4'd5, 4'd7};
        4'd1: q = {4'd5, 4'd6, 4'd3, 4'd8};
        4'd2: q = {4'd3, 4'd7, 4'd4, 4'd6};
        4'd3: q = {4'd2, 4'd7, 4'd1, 4'd8};
        4'd4: q = {4'd0, 4'd8, 4'd2, 4'd6};
        4'd5: q = {4'd1, 4'd6, 4'd0, 4'd7};
        4'd6: q = {4'd1, 4'd5, 4'd2, 4'd4};
        4'd7: q = {4'd2, 4'd3, 4'd0, 4'd5};
        4'd8: q = {4'd0, 4'd4, 4'd1, 4'd3};
        default: q = 16'd0;
      endcase
      c.a_src = ASRC_J;
      c.b_src = BSRC_J;
      c.part  = PART_FULL;
      if (!step[0]) begin
        c.a_idx  = q[15:12];
        c.b_idx  = q[11:8];
        c.acc_op = ACC_LOAD;
      end else begin
        c.a_idx   = q[7:4];
        c.b_idx   = q[3:0];
        c.acc_op  = ACC_SUB;
        c.dst     = DST_G;
        c.dst_idx = k;
      end
    end else begin
      c.a_src  = ASRC_G;
      c.a_idx  = {2'b00, off[2:1]};
      c.b_src  = BSRC_J;
      c.b_idx  = {2'b00, off[2:1]};
      c.part   = off[0] ? PART_HI : PART_LO;
      c.acc_op = (off == '0) ? ACC_LOAD : ACC_ADD;
      if (off == STEP_W'(PROD_STEPS - 1)) c.dst = DST_DET;
    end
    return c;
  endfunction

  // numerator k+1 = sum over axes of g[3k+i] * d[i], each product in halves
  function automatic mac_cmd_t mc_query(input logic [STEP_W-1:0] step);
    mac_cmd_t          c;
    logic [1:0]        k;
    logic [STEP_W-1:0] base;
    logic [STEP_W-1:0] off;
    c = mac_idle();
    c.mul_en = 1'b1;
    if (step < STEP_W'(PROD_STEPS)) begin
      k = 2'd0;
      base = '0;
    end else if (step < STEP_W'(2 * PROD_STEPS)) begin
      k = 2'd1;
      base = STEP_W'(PROD_STEPS);
    end else begin
      k = 2'd2;
      base = STEP_W'(2 * PROD_STEPS);
    end
    off = step - base;
    c.a_src  = ASRC_G;
    c.a_idx  = 4'({2'b00, k} * 4'd3 + {2'b00, off[2:1]});
    c.b_src  = BSRC_D;
    c.b_idx  = {2'b00, off[2:1]};
    c.part   = off[0] ? PART_HI : PART_LO;
    c.acc_op = (off == '0) ? ACC_LOAD : ACC_ADD;
    if (off == STEP_W'(PROD_STEPS - 1)) begin
      c.dst     = DST_N;
      c.dst_idx = {2'b00, k} + 4'd1;
    end
    return c;
  endfunction

endpackage

FILE: sv/tet_barycentric_point_locate_core.sv
// Top level of the tetrahedron point locator: controller plus datapath.
// Loads of vertex 0..2 give no result. Loading vertex 3 runs the setup
// (edge matrix, nine cofactors, determinant) on one shared 27x25
// multiply-accumulate unit with cofactors split in two halves, then gives
// a setup result. A query takes 18 multiply-accumulate steps plus four
// weight divisions on a bit-serial divider that yields one quotient bit
// per cycle, the four divisions running one after another.
// A query against a singular or unloaded tetrahedron skips the
// computation and goes straight to the output state.
// The result register lets the next transaction be accepted while a
// result waits.
module tet_barycentric_point_locate_core #(
  parameter int COORD_WIDTH    = tbp_pkg::COORD_WIDTH,
  parameter int BARY_FRAC_BITS = tbp_pkg::BARY_FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  tbp_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output tbp_pkg::out_item_t out_data
);

  tbp_pkg::ctl_cmd_t cmd;
  tbp_pkg::dp_stat_t stat;

  tbp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_kind   (in_data.kind),
    .in_vidx   (in_data.vertex_index),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  tbp_dp #(.CW(COORD_WIDTH), .F(BARY_FRAC_BITS)) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule

FILE: sv/tbp_div.sv
// Bit-serial restoring divider giving one rounded, saturated barycentric weight.
module tbp_div #(
  parameter int NW = 80,
  parameter int F  = tbp_pkg::BARY_FRAC_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [NW-1:0]              num,
  input  logic signed [NW-1:0]              den,
  output logic                              done,
  output logic signed [tbp_pkg::BARY_W-1:0] res,
  output logic                              nonneg
);

  localparam int BW    = tbp_pkg::BARY_W;
  localparam int QW    = BW + 2;
  localparam int DVW   = NW + F + 1;
  localparam int CNT_W = $clog2(DVW + 1);
  localparam logic [QW-1:0] POS_MAX = QW'((1 << (BW - 1)) - 1);
  localparam logic [QW-1:0] NEG_MAX = QW'(1 << (BW - 1));

  logic [NW-1:0]    num_abs, den_abs;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DVW-1:0]   dvd_r, dvd_nxt;
  logic [NW:0]      rem_r, rem_nxt;
  logic [NW-1:0]    md_r, md_nxt;
  logic [QW-1:0]    q_r, q_nxt;
  logic             sat_r, sat_nxt;
  logic             neg_r, neg_nxt;
  logic [NW:0]      rem_sh;
  logic             ge;
  logic [QW:0]      q_ext;
  logic [QW:0]      q_inc;
  logic [QW-1:0]    m, mag, mag_neg;

  assign num_abs = num[NW-1] ? (~num + 1'b1) : num;
  assign den_abs = den[NW-1] ? (~den + 1'b1) : den;

  assign rem_sh = {rem_r[NW-1:0], dvd_r[DVW-1]};
  assign ge     = rem_sh >= {1'b0, md_r};
  assign q_ext  = {q_r, ge};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    md_nxt   = md_r;
    q_nxt    = q_r;
    sat_nxt  = sat_r;
    neg_nxt  = neg_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(DVW);
      dvd_nxt  = {num_abs, (F + 1)'(0)};
      rem_nxt  = '0;
      md_nxt   = den_abs;
      q_nxt    = '0;
      sat_nxt  = 1'b0;
      neg_nxt  = (num[NW-1] != den[NW-1]) && (num != '0);
    end else if (busy_r) begin
      dvd_nxt = dvd_r << 1;
      rem_nxt = ge ? (rem_sh - {1'b0, md_r}) : rem_sh;
      q_nxt   = q_ext[QW-1:0];
      sat_nxt = sat_r | q_ext[QW];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    md_r  <= md_nxt;
    q_r   <= q_nxt;
    sat_r <= sat_nxt;
    neg_r <= neg_nxt;
  end

  // round half away from zero, then clamp to the signed output range
  always_comb begin
    q_inc = {1'b0, q_r} + (QW + 1)'(1);
    m     = q_inc[QW:1];
    if (neg_r) begin
      mag = (sat_r || m > NEG_MAX) ? NEG_MAX : m;
    end else begin
      mag = (sat_r || m > POS_MAX) ? POS_MAX : m;
    end
    mag_neg = ~mag + 1'b1;
    res     = neg_r ? mag_neg[BW-1:0] : mag[BW-1:0];
  end

  assign done   = done_r;
  assign nonneg = !neg_r;

endmodule

FILE: sv/tbp_dp.sv
// Datapath: vertex store, edge matrix, shared multiply-accumulate, weights, output register.
module tbp_dp #(
  parameter int CW = tbp_pkg::COORD_WIDTH,
  parameter int F  = tbp_pkg::BARY_FRAC_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  tbp_pkg::in_item_t   in_data,
  input  tbp_pkg::ctl_cmd_t   cmd,
  output tbp_pkg::dp_stat_t   stat,
  output tbp_pkg::out_item_t  out_data
);

  localparam int DW    = CW + 1;
  localparam int GW    = 2 * DW + 1;
  localparam int LOW_W = DW + 1;
  localparam int MA    = LOW_W + 1;
  localparam int PW    = MA + DW;
  localparam int NW    = GW + DW + 4;
  localparam int BW    = tbp_pkg::BARY_W;

  logic signed [CW-1:0] c_in [3];
  logic signed [CW-1:0] vtx_r [12];
  logic signed [DW-1:0] j_r [9];
  logic signed [GW-1:0] g_r [9];
  logic signed [DW-1:0] d_r [3];
  logic signed [NW-1:0] det_r;
  logic signed [NW-1:0] n_r [4];
  logic                 deg_r;
  logic signed [MA-1:0] a_op_r, a_op_nxt;
  logic signed [DW-1:0] b_op_r, b_op_nxt;
  logic signed [PW-1:0] p_r;
  tbp_pkg::mac_cmd_t    c1_r, c2_r;
  logic signed [NW-1:0] acc_r, acc_nxt, p_ext;
  logic signed [BW-1:0] w_r [4];
  logic [3:0]           nn_r;
  tbp_pkg::out_item_t   out_r, out_nxt;
  logic [3:0]           vbase;
  logic                 div_done, div_nonneg;
  logic signed [BW-1:0] div_res;

  assign c_in[0] = CW'(in_data.coord_x);
  assign c_in[1] = CW'(in_data.coord_y);
  assign c_in[2] = CW'(in_data.coord_z);
  assign vbase   = 4'({2'b00, in_data.vertex_index} * 4'd3);

  always_ff @(posedge clk) begin
    if (cmd.accept && in_data.kind == tbp_pkg::KIND_VERTEX) begin
      for (int a = 0; a < 3; a++) vtx_r[vbase + 4'(a)] <= c_in[a];
    end
    if (cmd.accept && in_data.kind == tbp_pkg::KIND_QUERY) begin
      for (int a = 0; a < 3; a++) d_r[a] <= DW'(c_in[a]) - DW'(vtx_r[a]);
    end
    if (cmd.calc_diff) begin
      for (int k = 1; k < 4; k++) begin
        for (int a = 0; a < 3; a++) begin
          j_r[(k - 1) * 3 + a] <= DW'(vtx_r[k * 3 + a]) - DW'(vtx_r[a]);
        end
      end
    end
  end

  // operand fetch; wide cofactors go through the multiplier in two halves
  always_comb begin
    case (cmd.mac.part)
      tbp_pkg::PART_LO: a_op_nxt = {1'b0, g_r[cmd.mac.a_idx][LOW_W-1:0]};
      tbp_pkg::PART_HI: a_op_nxt = MA'($signed(g_r[cmd.mac.a_idx][GW-1:LOW_W]));
      default:          a_op_nxt = MA'(j_r[cmd.mac.a_idx]);
    endcase
    b_op_nxt = (cmd.mac.b_src == tbp_pkg::BSRC_J) ? j_r[cmd.mac.b_idx] :
                                                   d_r[cmd.mac.b_idx[1:0]];
  end

  always_comb begin
    p_ext = NW'(p_r);
    if (c2_r.part == tbp_pkg::PART_HI) p_ext = p_ext <<< LOW_W;
    case (c2_r.acc_op)
      tbp_pkg::ACC_ADD: acc_nxt = acc_r + p_ext;
      tbp_pkg::ACC_SUB: acc_nxt = acc_r - p_ext;
      default:          acc_nxt = p_ext;
    endcase
  end

  always_comb begin
    out_nxt = '0;
    case (cmd.out_mode)
      tbp_pkg::OUT_SETUP: begin
        out_nxt.result_kind = tbp_pkg::RES_SETUP;
        out_nxt.singular    = deg_r;
      end
      tbp_pkg::OUT_QUERY: begin
        out_nxt.result_kind = tbp_pkg::RES_QUERY;
        out_nxt.bary_r      = w_r[0];
        out_nxt.bary_s      = w_r[1];
        out_nxt.bary_t      = w_r[2];
        out_nxt.bary_u      = w_r[3];
        out_nxt.inside_res  = &nn_r;
        out_nxt.singular    = 1'b0;
      end
      default: begin
        out_nxt.result_kind = tbp_pkg::RES_QUERY;
        out_nxt.singular    = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_r  <= tbp_pkg::mac_idle();
      c2_r  <= tbp_pkg::mac_idle();
      deg_r <= 1'b1;
      for (int e = 0; e < 9; e++) g_r[e] <= '0;
      det_r <= '0;
    end else begin
      c1_r <= cmd.mac;
      c2_r <= c1_r;
      if (cmd.set_deg) deg_r <= 1'b1;
      else if (cmd.calc_deg) deg_r <= (det_r == '0);
      if (c2_r.mul_en) begin
        case (c2_r.dst)
          tbp_pkg::DST_G:   g_r[c2_r.dst_idx] <= GW'(acc_nxt);
          tbp_pkg::DST_DET: det_r <= acc_nxt;
          default: ;
        endcase
      end
    end
    if (cmd.mac.mul_en) begin
      a_op_r <= a_op_nxt;
      b_op_r <= b_op_nxt;
    end
    if (c1_r.mul_en) p_r <= a_op_r * b_op_r;
    if (c2_r.mul_en) begin
      acc_r <= acc_nxt;
      if (c2_r.dst == tbp_pkg::DST_N) n_r[c2_r.dst_idx[1:0]] <= acc_nxt;
    end
    if (cmd.calc_n0) n_r[0] <= det_r - n_r[1] - n_r[2] - n_r[3];
    if (cmd.div_take) begin
      w_r[cmd.div_sel]  <= div_res;
      nn_r[cmd.div_sel] <= div_nonneg;
    end
    if (cmd.out_load) out_r <= out_nxt;
  end

  tbp_div #(.NW(NW), .F(F)) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cmd.div_start),
    .num    (n_r[cmd.div_sel]),
    .den    (det_r),
    .done   (div_done),
    .res    (div_res),
    .nonneg (div_nonneg)
  );

  assign stat.deg      = deg_r;
  assign stat.div_done = div_done;
  assign out_data      = out_r;

endmodule

FILE: sv/tbp_ctrl.sv
// Controller: transaction handshake, setup and query sequencing, output valid.
module tbp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_kind,
  input  logic [1:0]        in_vidx,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  tbp_pkg::dp_stat_t stat,
  output tbp_pkg::ctl_cmd_t cmd
);

  localparam int SW = tbp_pkg::STEP_W;
  localparam int DR = tbp_pkg::DRAIN_W;

  tbp_pkg::state_t    state_r, state_nxt;
  logic [SW-1:0]      step_r, step_nxt;
  logic [DR-1:0]      drain_r, drain_nxt;
  logic [1:0]         widx_r, widx_nxt;
  tbp_pkg::out_mode_t omode_r, omode_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               accept, out_load;

  assign accept   = in_valid && state_r == tbp_pkg::ST_IDLE;
  assign out_load = state_r == tbp_pkg::ST_OUT && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    drain_nxt = drain_r;
    widx_nxt  = widx_r;
    omode_nxt = omode_r;
    case (state_r)
      tbp_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_kind == tbp_pkg::KIND_VERTEX) begin
            if (in_vidx == tbp_pkg::LAST_VERTEX) state_nxt = tbp_pkg::ST_DIFF;
          end else if (stat.deg) begin
            omode_nxt = tbp_pkg::OUT_SING;
            state_nxt = tbp_pkg::ST_OUT;
          end else begin
            step_nxt  = '0;
            state_nxt = tbp_pkg::ST_QMAC;
          end
        end
      end
      tbp_pkg::ST_DIFF: begin
        step_nxt  = '0;
        state_nxt = tbp_pkg::ST_SMAC;
      end
      tbp_pkg::ST_SMAC: begin
        step_nxt = step_r + 1'b1;
        if (step_r == SW'(tbp_pkg::SETUP_STEPS - 1)) begin
          drain_nxt = '0;
          state_nxt = tbp_pkg::ST_SDRAIN;
        end
      end
      tbp_pkg::ST_SDRAIN: begin
        drain_nxt = drain_r + 1'b1;
        if (drain_r == DR'(tbp_pkg::MAC_LAT - 1)) state_nxt = tbp_pkg::ST_SCHK;
      end
      tbp_pkg::ST_SCHK: begin
        omode_nxt = tbp_pkg::OUT_SETUP;
        state_nxt = tbp_pkg::ST_OUT;
      end
      tbp_pkg::ST_QMAC: begin
        step_nxt = step_r + 1'b1;
        if (step_r == SW'(tbp_pkg::QUERY_STEPS - 1)) begin
          drain_nxt = '0;
          state_nxt = tbp_pkg::ST_QDRAIN;
        end
      end
      tbp_pkg::ST_QDRAIN: begin
        drain_nxt = drain_r + 1'b1;
        if (drain_r == DR'(tbp_pkg::MAC_LAT - 1)) state_nxt = tbp_pkg::ST_QN0;
      end
      tbp_pkg::ST_QN0: begin
        widx_nxt  = 2'd0;
        state_nxt = tbp_pkg::ST_DSTART;
      end
      tbp_pkg::ST_DSTART: state_nxt = tbp_pkg::ST_DWAIT;
      tbp_pkg::ST_DWAIT: begin
        if (stat.div_done) begin
          if (widx_r == 2'd3) begin
            omode_nxt = tbp_pkg::OUT_QUERY;
            state_nxt = tbp_pkg::ST_OUT;
          end else begin
            widx_nxt  = widx_r + 1'b1;
            state_nxt = tbp_pkg::ST_DSTART;
          end
        end
      end
      tbp_pkg::ST_OUT: begin
        if (out_load) state_nxt = tbp_pkg::ST_IDLE;
      end
      default: state_nxt = tbp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.mac       = tbp_pkg::mac_idle();
    cmd.accept    = accept;
    cmd.set_deg   = accept && in_kind == tbp_pkg::KIND_VERTEX &&
                    in_vidx != tbp_pkg::LAST_VERTEX;
    cmd.div_sel   = widx_r;
    cmd.out_mode  = omode_r;
    cmd.out_load  = out_load;
    case (state_r)
      tbp_pkg::ST_DIFF:   cmd.calc_diff = 1'b1;
      tbp_pkg::ST_SMAC:   cmd.mac       = tbp_pkg::mc_setup(step_r);
      tbp_pkg::ST_SCHK:   cmd.calc_deg  = 1'b1;
      tbp_pkg::ST_QMAC:   cmd.mac       = tbp_pkg::mc_query(step_r);
      tbp_pkg::ST_QN0:    cmd.calc_n0   = 1'b1;
      tbp_pkg::ST_DSTART: cmd.div_start = 1'b1;
      tbp_pkg::ST_DWAIT:  cmd.div_take  = stat.div_done;
      default: ;
    endcase
  end

  assign out_valid_nxt = out_load ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tbp_pkg::ST_IDLE;
      step_r      <= '0;
      drain_r     <= '0;
      widx_r      <= '0;
      omode_r     <= tbp_pkg::OUT_SETUP;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      drain_r     <= drain_nxt;
      widx_r      <= widx_nxt;
      omode_r     <= omode_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = state_r != tbp_pkg::ST_IDLE;
  assign out_valid = out_valid_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || !out_stall))
    else $error("pending result overwritten");

  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    stat.div_done |-> state_r == tbp_pkg::ST_DWAIT)
    else $error("divider finished outside wait state");

  a_last_weight: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tbp_pkg::ST_DWAIT && stat.div_done && widx_r == 2'd3)
    |=> state_r == tbp_pkg::ST_OUT)
    else $error("query result not issued after last weight");

  a_setup_start: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_kind == tbp_pkg::KIND_VERTEX && in_vidx == tbp_pkg::LAST_VERTEX)
    |=> state_r == tbp_pkg::ST_DIFF)
    else $error("setup not started on last vertex");

endmodule
